@@ rtl/core/aip_pkg.sv @@
// Shared types, constants and character classification for the ASCII integer parser.
package aip_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int INC_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [BASE_W-1:0] BASE_RESET  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN    = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT    = 6'h3F;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LO_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UP_B    = 8'h42;
    localparam logic [CHAR_W-1:0] CHAR_LO_B    = 8'h62;
    localparam logic [CHAR_W-1:0] UP_LETTER_OFS = 8'd55;
    localparam logic [CHAR_W-1:0] LO_LETTER_OFS = 8'd87;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [BASE_W-1:0] digit;
        logic              is_space;
        logic              is_plus;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
        logic              is_b;
    } class_t;

    function automatic class_t classify(input logic [CHAR_W-1:0] c);
        class_t r;
        r.digit = NO_DIGIT;
        if (c inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            r.digit = BASE_W'(c - CHAR_ZERO);
        end
        else if (c inside {[CHAR_UP_A:CHAR_UP_Z]})
        begin
            r.digit = BASE_W'(c - UP_LETTER_OFS);
        end
        else if (c inside {[CHAR_LO_A:CHAR_LO_Z]})
        begin
            r.digit = BASE_W'(c - LO_LETTER_OFS);
        end
        r.is_space = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
        r.is_plus  = (c == CHAR_PLUS);
        r.is_minus = (c == CHAR_MINUS);
        r.is_zero  = (c == CHAR_ZERO);
        r.is_x     = (c == CHAR_LO_X) || (c == CHAR_UP_X);
        r.is_b     = (c == CHAR_LO_B) || (c == CHAR_UP_B);
        return r;
    endfunction

endpackage

@@ rtl/core/aip_front.sv @@
// Front stage: accept characters and register their classification.
module aip_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // char_code
    output logic                  cls_valid,
    input  logic                  cls_ready,
    output aip_pkg::class_t       cls_item
);

    logic            valid_reg;
    logic            valid_next;
    aip_pkg::class_t item_reg;

    assign s_tready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= aip_pkg::classify(s_tdata);
        end
    end

endmodule

@@ rtl/core/aip_fifo.sv @@
// Short queue between the front and back stages.
module aip_fifo
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = aip_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower count");

endmodule

@@ rtl/core/aip_back.sv @@
// Back stage: parse state machine, digit accumulation and result register.
module aip_back
#(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = aip_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [aip_pkg::BASE_W-1:0]         number_base,
    input  logic                               signed_mode,
    input  logic                               cls_valid,
    output logic                               cls_ready,
    input  aip_pkg::class_t                    cls_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [VALUE_WIDTH-1:0]             res_value,
    output logic [COUNT_WIDTH-1:0]             res_count,
    output logic                               res_overflowed,
    output logic                               res_found
);

    localparam int BW     = aip_pkg::BASE_W;
    localparam int PROD_W = VALUE_WIDTH + BW + 1;
    localparam logic [VALUE_WIDTH-1:0] HALF    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] HALF_M1 = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] ALL_ONE = {VALUE_WIDTH{1'b1}};

    aip_pkg::phase_t          phase_reg, phase_next;
    logic                     neg_reg;
    logic [VALUE_WIDTH-1:0]   acc_reg;
    logic                     ovf_reg;
    logic                     seen_reg;
    logic [BW-1:0]            base_reg;
    logic [COUNT_WIDTH-1:0]   cnt_reg;

    logic                     out_valid_reg;
    logic [VALUE_WIDTH-1:0]   out_value_reg;
    logic [COUNT_WIDTH-1:0]   out_count_reg;
    logic                     out_ovf_reg;
    logic                     out_found_reg;

    logic                     pop;
    logic                     base_special;
    logic                     zero_pfx;
    logic [BW-1:0]            first_base;
    logic                     first_ok;
    logic                     cont_ok;
    logic                     hex_pfx;
    logic                     bin_pfx;

    logic                     act_take;
    logic                     act_finish;
    logic                     act_clear;
    logic                     act_seen;
    logic                     act_set_base;
    logic [BW-1:0]            act_base;
    logic                     act_set_neg;
    logic [aip_pkg::INC_W-1:0] act_inc;
    logic [BW-1:0]            eff_base;

    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        lim;
    logic [VALUE_WIDTH-1:0]   lim_v;
    logic [COUNT_WIDTH:0]     cnt_sum;
    logic [COUNT_WIDTH-1:0]   cnt_new;
    logic [VALUE_WIDTH-1:0]   fin_value;

    assign pop       = cls_valid && (!out_valid_reg || m_tready);
    assign cls_ready = !out_valid_reg || m_tready;

    assign base_special = (number_base == aip_pkg::BASE_AUTO)
                       || (number_base == aip_pkg::BASE_HEX)
                       || (number_base == aip_pkg::BASE_BIN);
    assign zero_pfx = cls_item.is_zero && base_special;

    always_comb
    begin
        if (number_base == aip_pkg::BASE_AUTO)
        begin
            first_base = aip_pkg::BASE_DEC;
        end
        else if (number_base inside {[aip_pkg::BASE_BIN:aip_pkg::BASE_MAX]})
        begin
            first_base = number_base;
        end
        else
        begin
            first_base = '0;
        end
    end

    assign first_ok = (cls_item.digit < first_base);
    assign cont_ok  = (cls_item.digit < base_reg);
    assign hex_pfx  = cls_item.is_x && ((number_base == aip_pkg::BASE_AUTO)
                                     || (number_base == aip_pkg::BASE_HEX));
    assign bin_pfx  = cls_item.is_b && ((number_base == aip_pkg::BASE_AUTO)
                                     || (number_base == aip_pkg::BASE_BIN));

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            aip_pkg::PH_SPACE, aip_pkg::PH_SIGNED:
            begin
                if (phase_reg == aip_pkg::PH_SPACE && cls_item.is_space)
                begin
                    phase_next = aip_pkg::PH_SPACE;
                end
                else if (phase_reg == aip_pkg::PH_SPACE
                         && (cls_item.is_plus || cls_item.is_minus))
                begin
                    phase_next = aip_pkg::PH_SIGNED;
                end
                else if (zero_pfx)
                begin
                    phase_next = aip_pkg::PH_ZERO;
                end
                else if (first_ok)
                begin
                    phase_next = aip_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_next = aip_pkg::PH_SPACE;
                end
            end
            aip_pkg::PH_ZERO:
            begin
                if (hex_pfx || bin_pfx)
                begin
                    phase_next = aip_pkg::PH_PREFIX;
                end
                else if (cont_ok)
                begin
                    phase_next = aip_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_next = aip_pkg::PH_SPACE;
                end
            end
            aip_pkg::PH_PREFIX, aip_pkg::PH_DIGITS:
            begin
                phase_next = cont_ok ? aip_pkg::PH_DIGITS : aip_pkg::PH_SPACE;
            end
            default:
            begin
                phase_next = aip_pkg::PH_SPACE;
            end
        endcase
    end

    always_comb
    begin
        act_take     = 1'b0;
        act_finish   = 1'b0;
        act_clear    = 1'b0;
        act_seen     = 1'b0;
        act_set_base = 1'b0;
        act_base     = base_reg;
        act_set_neg  = 1'b0;
        act_inc      = '0;
        eff_base     = base_reg;
        case (phase_reg)
            aip_pkg::PH_SPACE, aip_pkg::PH_SIGNED:
            begin
                if (phase_reg == aip_pkg::PH_SPACE && cls_item.is_space)
                begin
                    act_inc = 2'd1;
                end
                else if (phase_reg == aip_pkg::PH_SPACE
                         && (cls_item.is_plus || cls_item.is_minus))
                begin
                    act_inc     = 2'd1;
                    act_set_neg = 1'b1;
                end
                else if (zero_pfx)
                begin
                    act_inc      = 2'd1;
                    act_seen     = 1'b1;
                    act_set_base = 1'b1;
                    act_base     = (number_base == aip_pkg::BASE_AUTO)
                                 ? aip_pkg::BASE_OCT : number_base;
                end
                else if (first_ok)
                begin
                    act_take     = 1'b1;
                    act_inc      = 2'd1;
                    act_set_base = 1'b1;
                    act_base     = first_base;
                    eff_base     = first_base;
                end
                else
                begin
                    act_finish = 1'b1;
                end
            end
            aip_pkg::PH_ZERO:
            begin
                if (hex_pfx)
                begin
                    act_set_base = 1'b1;
                    act_base     = aip_pkg::BASE_HEX;
                end
                else if (bin_pfx)
                begin
                    act_set_base = 1'b1;
                    act_base     = aip_pkg::BASE_BIN;
                end
                else if (cont_ok)
                begin
                    act_take = 1'b1;
                    act_inc  = 2'd1;
                end
                else
                begin
                    act_finish = 1'b1;
                end
            end
            aip_pkg::PH_PREFIX:
            begin
                if (cont_ok)
                begin
                    act_take = 1'b1;
                    act_inc  = 2'd2;
                end
                else
                begin
                    act_finish = 1'b1;
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                if (cont_ok)
                begin
                    act_take = 1'b1;
                    act_inc  = 2'd1;
                end
                else
                begin
                    act_finish = 1'b1;
                end
            end
            default:
            begin
                act_clear = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (!signed_mode)
        begin
            lim_v = ALL_ONE;
        end
        else
        begin
            lim_v = neg_reg ? HALF : HALF_M1;
        end
    end

    assign lim  = PROD_W'(lim_v);
    assign prod = PROD_W'(acc_reg) * PROD_W'(eff_base) + PROD_W'(cls_item.digit);

    assign cnt_sum = {1'b0, cnt_reg} + (COUNT_WIDTH+1)'(act_inc);
    assign cnt_new = cnt_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : cnt_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        if (!seen_reg)
        begin
            fin_value = '0;
        end
        else if (ovf_reg)
        begin
            fin_value = lim_v;
        end
        else if (neg_reg)
        begin
            fin_value = {VALUE_WIDTH{1'b0}} - acc_reg;
        end
        else
        begin
            fin_value = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= aip_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                phase_reg <= phase_next;
                if (act_finish || act_clear)
                begin
                    neg_reg  <= 1'b0;
                    acc_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    seen_reg <= 1'b0;
                    base_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_new;
                    if (act_seen || act_take)
                    begin
                        seen_reg <= 1'b1;
                    end
                    if (act_set_base)
                    begin
                        base_reg <= act_base;
                    end
                    if (act_set_neg)
                    begin
                        neg_reg <= cls_item.is_minus;
                    end
                    if (act_take && !ovf_reg)
                    begin
                        if (prod > lim)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg <= prod[VALUE_WIDTH-1:0];
                        end
                    end
                end
                if (act_finish)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && act_finish)
        begin
            out_value_reg <= fin_value;
            out_count_reg <= seen_reg ? cnt_reg : '0;
            out_ovf_reg   <= seen_reg && ovf_reg;
            out_found_reg <= seen_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign res_value      = out_value_reg;
    assign res_count      = out_count_reg;
    assign res_overflowed = out_ovf_reg;
    assign res_found      = out_found_reg;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg)
        |-> (out_value_reg == '0 && out_count_reg == '0 && !out_ovf_reg))
        else $error("result without digits is not all zero");

    a_prefix_base: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == aip_pkg::PH_PREFIX)
        |-> (base_reg == aip_pkg::BASE_HEX || base_reg == aip_pkg::BASE_BIN))
        else $error("prefix phase with wrong radix");

    a_zero_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == aip_pkg::PH_ZERO) |-> seen_reg)
        else $error("leading zero not counted as digit");

    a_ovf_seen: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> seen_reg)
        else $error("overflow without digits");

endmodule

@@ rtl/core/ascii_integer_parser_top.sv @@
// Top level of the streaming ASCII integer parser.
// Throughput: one character per cycle, sustained, while the result side keeps up.
// The ending character passes the front register and queue; the result register drives m_tvalid.
// The front register and a two-entry queue let input and parse state stall separately.
// The digit step is one multiply-accumulate with range check per cycle that pops a character.
// Reset (rst_n low, asynchronous) clears all control state; number_base is 10, signed_mode is 1.
module ascii_integer_parser_top
#(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = aip_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // char_code
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // value, consumed_count, zero fill
    output logic [((VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                            m_tuser,   // overflowed, found_digits
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aip_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [aip_pkg::BASE_W-1:0]            cfg_data
);

    localparam int DATA_W = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - VALUE_WIDTH - COUNT_WIDTH;
    localparam int ITEM_W = $bits(aip_pkg::class_t);

    logic [aip_pkg::BASE_W-1:0] base_reg;
    logic                       signed_reg;

    logic            f_valid, f_ready;
    aip_pkg::class_t f_item;
    logic            q_valid, q_ready;
    logic [ITEM_W-1:0] q_data;
    logic [ITEM_W-1:0] f_data;

    logic [VALUE_WIDTH-1:0] res_value;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   res_overflowed;
    logic                   res_found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= aip_pkg::BASE_RESET;
            signed_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aip_pkg::REG_NUMBER_BASE: base_reg   <= cfg_data;
                aip_pkg::REG_SIGNED_MODE: signed_reg <= cfg_data[0];
                default:                  base_reg   <= base_reg;
            endcase
        end
    end

    aip_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_item  (f_item)
    );

    assign f_data = f_item;

    aip_fifo
    #(
        .WIDTH (ITEM_W),
        .DEPTH (aip_pkg::QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    aip_back
    #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .number_base    (base_reg),
        .signed_mode    (signed_reg),
        .cls_valid      (q_valid),
        .cls_ready      (q_ready),
        .cls_item       (aip_pkg::class_t'(q_data)),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .res_value      (res_value),
        .res_count      (res_count),
        .res_overflowed (res_overflowed),
        .res_found      (res_found)
    );

    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, res_count, res_value};
        end
        else
        begin : g_nopad
            assign m_tdata = {res_count, res_value};
        end
    endgenerate

    assign m_tuser = {res_found, res_overflowed};

endmodule

@@ verif/tb_ascii_integer_parser_top.sv @@
// Self-checking testbench for the streaming ASCII integer parser top level.
module tb_ascii_integer_parser_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W     = aip_pkg::VALUE_WIDTH_DEF;
    localparam int COUNT_W     = aip_pkg::COUNT_WIDTH_DEF;
    localparam int DATA_W      = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int NOT_DIGIT   = 99;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_LEN    = 200;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [aip_pkg::CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [aip_pkg::CHAR_W-1:0] CHAR_TOP   = 8'hFF;
    localparam logic [aip_pkg::CHAR_W-1:0] CHAR_COMMA = 8'h2C;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] consumed;
        logic               overflowed;
        logic               found_digits;
    } number_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [DATA_W-1:0]              m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [aip_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [aip_pkg::BASE_W-1:0]     cfg_data;

    number_result_t expected_numbers[$];

    logic [aip_pkg::BASE_W-1:0] base_q;
    logic                       signed_q;

    aip_pkg::phase_t   scan_phase;
    logic              scan_neg;
    logic [63:0]       scan_acc;
    logic              scan_ovf;
    logic              scan_digit;
    int                scan_radix;
    int                scan_count;

    int  failures      = 0;
    int  chars_sent    = 0;
    int  numbers_seen  = 0;
    int  clamped_seen  = 0;
    int  empty_seen    = 0;
    int  reg_writes    = 0;
    int  hold_cycles   = 0;
    int  cycle_count   = 0;
    bit  no_idle       = 1'b0;

    ascii_integer_parser_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_ascii_integer_parser_top: FAIL");
            $finish;
        end
    end

    function automatic int char_digit(logic [7:0] c);
        if (c >= aip_pkg::CHAR_ZERO && c <= aip_pkg::CHAR_NINE)
            return int'(c - aip_pkg::CHAR_ZERO);
        if (c >= aip_pkg::CHAR_UP_A && c <= aip_pkg::CHAR_UP_Z)
            return int'(c - aip_pkg::CHAR_UP_A) + 10;
        if (c >= aip_pkg::CHAR_LO_A && c <= aip_pkg::CHAR_LO_Z)
            return int'(c - aip_pkg::CHAR_LO_A) + 10;
        return NOT_DIGIT;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == aip_pkg::CHAR_SPACE) || (c >= aip_pkg::CHAR_TAB && c <= aip_pkg::CHAR_CR);
    endfunction

    function automatic logic [7:0] digit_char(int d);
        if (d < 10)
            return aip_pkg::CHAR_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? aip_pkg::CHAR_LO_A : aip_pkg::CHAR_UP_A) + 8'(d - 10);
    endfunction

    task automatic clear_scan();
        scan_phase = aip_pkg::PH_SPACE;
        scan_neg   = 1'b0;
        scan_acc   = '0;
        scan_ovf   = 1'b0;
        scan_digit = 1'b0;
        scan_radix = 0;
        scan_count = 0;
    endtask

    task automatic count_char();
        if (scan_count < COUNT_MAX)
            scan_count++;
    endtask

    task automatic take_digit_value(int d);
        logic [63:0] lim;
        logic [63:0] cut;
        logic [63:0] rem;
        count_char();
        scan_digit = 1'b1;
        if (!scan_ovf && scan_radix >= 2)
        begin
            if (!signed_q)
                lim = 64'hFFFF_FFFF;
            else
                lim = scan_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            cut = lim / scan_radix;
            rem = lim % scan_radix;
            if (scan_acc > cut || (scan_acc == cut && d > rem))
                scan_ovf = 1'b1;
            else
                scan_acc = scan_acc * scan_radix + d;
        end
    endtask

    task automatic emit_number();
        number_result_t r;
        r.value        = '0;
        r.consumed     = '0;
        r.overflowed   = 1'b0;
        r.found_digits = 1'b0;
        if (scan_digit)
        begin
            r.found_digits = 1'b1;
            r.consumed     = scan_count[COUNT_W-1:0];
            if (scan_ovf)
            begin
                r.overflowed = 1'b1;
                if (!signed_q)
                    r.value = 32'hFFFF_FFFF;
                else
                    r.value = scan_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                r.value = scan_neg ? 32'(-scan_acc) : scan_acc[VALUE_W-1:0];
            end
        end
        expected_numbers.push_back(r);
        clear_scan();
    endtask

    task automatic open_number(logic [7:0] c, int d);
        int b;
        b = int'(base_q);
        if (c == aip_pkg::CHAR_ZERO
            && (b == aip_pkg::BASE_AUTO || b == aip_pkg::BASE_HEX || b == aip_pkg::BASE_BIN))
        begin
            count_char();
            scan_digit = 1'b1;
            scan_radix = (b == aip_pkg::BASE_AUTO) ? int'(aip_pkg::BASE_OCT) : b;
            scan_phase = aip_pkg::PH_ZERO;
        end
        else
        begin
            if (b == aip_pkg::BASE_AUTO)
                scan_radix = aip_pkg::BASE_DEC;
            else if (b >= aip_pkg::BASE_BIN && b <= aip_pkg::BASE_MAX)
                scan_radix = b;
            else
                scan_radix = 0;
            if (d < scan_radix)
            begin
                take_digit_value(d);
                scan_phase = aip_pkg::PH_DIGITS;
            end
            else
            begin
                emit_number();
            end
        end
    endtask

    task automatic predict_char(logic [7:0] c);
        int d;
        int b;
        d = char_digit(c);
        b = int'(base_q);
        case (scan_phase)
            aip_pkg::PH_SPACE:
            begin
                if (is_blank(c))
                begin
                    count_char();
                end
                else if (c == aip_pkg::CHAR_PLUS || c == aip_pkg::CHAR_MINUS)
                begin
                    scan_neg = (c == aip_pkg::CHAR_MINUS);
                    count_char();
                    scan_phase = aip_pkg::PH_SIGNED;
                end
                else
                begin
                    open_number(c, d);
                end
            end
            aip_pkg::PH_SIGNED:
            begin
                open_number(c, d);
            end
            aip_pkg::PH_ZERO:
            begin
                if ((c == aip_pkg::CHAR_LO_X || c == aip_pkg::CHAR_UP_X)
                    && (b == aip_pkg::BASE_AUTO || b == aip_pkg::BASE_HEX))
                begin
                    scan_radix = aip_pkg::BASE_HEX;
                    scan_phase = aip_pkg::PH_PREFIX;
                end
                else if ((c == aip_pkg::CHAR_LO_B || c == aip_pkg::CHAR_UP_B)
                         && (b == aip_pkg::BASE_AUTO || b == aip_pkg::BASE_BIN))
                begin
                    scan_radix = aip_pkg::BASE_BIN;
                    scan_phase = aip_pkg::PH_PREFIX;
                end
                else if (d < scan_radix)
                begin
                    take_digit_value(d);
                    scan_phase = aip_pkg::PH_DIGITS;
                end
                else
                begin
                    emit_number();
                end
            end
            aip_pkg::PH_PREFIX:
            begin
                if (d < scan_radix)
                begin
                    count_char();
                    take_digit_value(d);
                    scan_phase = aip_pkg::PH_DIGITS;
                end
                else
                begin
                    emit_number();
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                if (d < scan_radix)
                    take_digit_value(d);
                else
                    emit_number();
            end
            default:
            begin
                clear_scan();
            end
        endcase
    endtask

    task automatic send_char(logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        predict_char(c);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic write_reg(logic [aip_pkg::CFG_IDX_W-1:0] idx,
                             logic [aip_pkg::BASE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == aip_pkg::REG_NUMBER_BASE)
            base_q = data;
        else
            signed_q = data[0];
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_parser();
        s_tvalid <= 1'b0;
        while (expected_numbers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic send_random_string();
        string edge_dec[6] = '{"2147483647", "2147483648", "-2147483648",
                               "-2147483649", "4294967295", "4294967296"};
        string edge_hex[6] = '{"7fffffff", "80000000", "-80000000",
                               "-80000001", "FFFFFFFF", "100000000"};
        int eff;
        int ndig;
        int d;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
            return;
        end
        if ((base_q == aip_pkg::BASE_DEC || base_q == aip_pkg::BASE_HEX)
            && $urandom_range(0, 7) == 0)
        begin
            if (base_q == aip_pkg::BASE_DEC)
                send_text(edge_dec[$urandom_range(0, 5)]);
            else
                send_text(edge_hex[$urandom_range(0, 5)]);
            send_char(CHAR_NUL);
            return;
        end
        repeat ($urandom_range(0, 2))
            send_char($urandom_range(0, 1) ? aip_pkg::CHAR_SPACE : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 5))
            0: send_char(aip_pkg::CHAR_PLUS);
            1: send_char(aip_pkg::CHAR_MINUS);
            default: ;
        endcase
        if (base_q == aip_pkg::BASE_AUTO)
            eff = aip_pkg::BASE_DEC;
        else if (base_q >= aip_pkg::BASE_BIN && base_q <= aip_pkg::BASE_MAX)
            eff = int'(base_q);
        else
            eff = 36;
        if ((base_q == aip_pkg::BASE_AUTO || base_q == aip_pkg::BASE_HEX)
            && $urandom_range(0, 2) == 0)
        begin
            send_char(aip_pkg::CHAR_ZERO);
            send_char($urandom_range(0, 1) ? aip_pkg::CHAR_LO_X : aip_pkg::CHAR_UP_X);
            eff = aip_pkg::BASE_HEX;
        end
        else if ((base_q == aip_pkg::BASE_AUTO || base_q == aip_pkg::BASE_BIN)
                 && $urandom_range(0, 2) == 0)
        begin
            send_char(aip_pkg::CHAR_ZERO);
            send_char($urandom_range(0, 1) ? aip_pkg::CHAR_LO_B : aip_pkg::CHAR_UP_B);
            eff = aip_pkg::BASE_BIN;
        end
        else if (base_q == aip_pkg::BASE_AUTO && $urandom_range(0, 3) == 0)
        begin
            send_char(aip_pkg::CHAR_ZERO);
            eff = aip_pkg::BASE_OCT;
        end
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
        repeat (ndig)
        begin
            d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 35) : $urandom_range(0, eff - 1);
            send_char(digit_char(d));
        end
        case ($urandom_range(0, 3))
            0: send_char(CHAR_NUL);
            1: send_char(aip_pkg::CHAR_SPACE);
            2: send_char(8'($urandom_range(0, 255)));
            default: send_char(CHAR_COMMA);
        endcase
    endtask

    task automatic test_default_registers();
        send_text("\t-7");
        send_char(CHAR_TOP);
        send_char(CHAR_NUL);
    endtask

    task automatic test_auto_prefix();
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, aip_pkg::BASE_AUTO);
        send_text("0xg017 ");
    endtask

    task automatic test_overflow_clamp();
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, aip_pkg::BASE_MAX);
        write_reg(aip_pkg::REG_SIGNED_MODE, 6'd0);
        send_text("-zzzzzzz1");
        send_char(CHAR_NUL);
    endtask

    task automatic test_invalid_radix();
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, 6'h3F);
        send_text("5");
    endtask

    task automatic test_midstring_change();
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, aip_pkg::BASE_DEC);
        write_reg(aip_pkg::REG_SIGNED_MODE, 6'd1);
        send_text("1");
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, aip_pkg::BASE_HEX);
        send_text("f-9");
        drain_parser();
        write_reg(aip_pkg::REG_SIGNED_MODE, 6'd0);
        send_char(CHAR_NUL);
    endtask

    task automatic test_result_backpressure();
        drain_parser();
        write_reg(aip_pkg::REG_NUMBER_BASE, aip_pkg::BASE_DEC);
        write_reg(aip_pkg::REG_SIGNED_MODE, 6'd1);
        no_idle     = 1'b1;
        hold_cycles = HOLD_LEN;
        repeat (40)
        begin
            send_char(digit_char($urandom_range(0, 9)));
            send_char(CHAR_NUL);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_strings();
        int start;
        logic [aip_pkg::BASE_W-1:0] b;
        for (int p = 0; p < 8; p++)
        begin
            drain_parser();
            case (p)
                0: b = aip_pkg::BASE_AUTO;
                1: b = aip_pkg::BASE_MAX;
                2: b = aip_pkg::BASE_BIN;
                3: b = aip_pkg::BASE_HEX;
                4: b = aip_pkg::BASE_DEC;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: b = aip_pkg::BASE_AUTO;
                        1: b = 6'($urandom_range(37, 63));
                        default: b = 6'($urandom_range(2, 36));
                    endcase
                end
            endcase
            write_reg(aip_pkg::REG_NUMBER_BASE, b);
            write_reg(aip_pkg::REG_SIGNED_MODE, 6'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            start = chars_sent;
            while (chars_sent - start < 100)
                send_random_string();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_check
        number_result_t want;
        logic [VALUE_W-1:0] got_value;
        logic [COUNT_W-1:0] got_count;
        logic got_ovf;
        logic got_found;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got_value = m_tdata[VALUE_W-1:0];
            got_count = m_tdata[VALUE_W +: COUNT_W];
            got_ovf   = m_tuser[0];
            got_found = m_tuser[1];
            numbers_seen++;
            if (expected_numbers.size() == 0)
            begin
                $error("unexpected item: value %h consumed_count %0d", got_value, got_count);
                failures++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (want.overflowed)
                    clamped_seen++;
                if (!want.found_digits)
                    empty_seen++;
                if (got_value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, got_value);
                    failures++;
                end
                if (got_count !== want.consumed)
                begin
                    $error("consumed_count: expected %0d, got %0d", want.consumed, got_count);
                    failures++;
                end
                if (got_ovf !== want.overflowed)
                begin
                    $error("overflowed: expected %b, got %b", want.overflowed, got_ovf);
                    failures++;
                end
                if (got_found !== want.found_digits)
                begin
                    $error("found_digits: expected %b, got %b", want.found_digits, got_found);
                    failures++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : main_sequence
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        base_q    = aip_pkg::BASE_RESET;
        signed_q  = 1'b1;
        clear_scan();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_registers();
        test_auto_prefix();
        test_overflow_clamp();
        test_invalid_radix();
        test_midstring_change();
        test_result_backpressure();
        test_random_strings();
        drain_parser();

        $display("Parsed %0d characters into %0d numbers (%0d clamped, %0d without digits)",
                 chars_sent, numbers_seen, clamped_seen, empty_seen);
        $display("over %0d register writes, with a long result hold-off and random radix runs",
                 reg_writes);
        if (failures == 0 && expected_numbers.size() == 0)
            $display("tb_ascii_integer_parser_top: PASS");
        else
            $display("tb_ascii_integer_parser_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/aip_pkg.sv
rtl/core/aip_front.sv
rtl/core/aip_fifo.sv
rtl/core/aip_back.sv
rtl/core/ascii_integer_parser_top.sv
verif/tb_ascii_integer_parser_top.sv
